// ===== src/ear_pkg.sv =====
// ----------------------------------------------------------------------------
// ear_pkg
// Shared constants and the CORDIC arctangent table for the attitude rotator.
// ----------------------------------------------------------------------------
package ear_pkg;

    localparam int VEC_FRAC_BITS_DEF = 16;
    localparam int ANGLE_BITS_DEF    = 16;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_COUNT        = 30;
    localparam int GUARD             = 2;
    localparam int KSHIFT            = 26;
    localparam int KGAIN_W           = 27;
    localparam logic [KGAIN_W-1:0] KGAIN = 27'd40752055;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

    typedef enum logic
    {
        OP_FORWARD = 1'b0,
        OP_REVERSE = 1'b1
    } op_t;

    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] r;
        begin
            case (i)
                0: r = 32'd536870912;
                1: r = 32'd316933406;
                2: r = 32'd167458907;
                3: r = 32'd85004756;
                4: r = 32'd42667331;
                5: r = 32'd21354465;
                6: r = 32'd10679838;
                7: r = 32'd5340245;
                8: r = 32'd2670163;
                9: r = 32'd1335087;
                10: r = 32'd667544;
                11: r = 32'd333772;
                12: r = 32'd166886;
                13: r = 32'd83443;
                14: r = 32'd41722;
                15: r = 32'd20861;
                16: r = 32'd10430;
                17: r = 32'd5215;
                18: r = 32'd2608;
                19: r = 32'd1304;
                20: r = 32'd652;
                21: r = 32'd326;
                22: r = 32'd163;
                23: r = 32'd81;
                24: r = 32'd41;
                25: r = 32'd20;
                26: r = 32'd10;
                27: r = 32'd5;
                28: r = 32'd3;
                29: r = 32'd1;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== src/ear_if.sv =====
// ----------------------------------------------------------------------------
// ear_in_if / ear_out_if
// Valid/ready channels carrying input vectors and rotated results.
// ----------------------------------------------------------------------------
interface ear_in_if #(
    parameter int VW = 18,
    parameter int AW = 16
);
    logic                 valid;
    logic                 ready;
    logic                 op;
    logic signed [VW-1:0] vec_x;
    logic signed [VW-1:0] vec_y;
    logic signed [VW-1:0] vec_z;
    logic [AW-1:0]        yaw;
    logic [AW-1:0]        pitch;
    logic [AW-1:0]        roll;

    modport source (output valid, op, vec_x, vec_y, vec_z, yaw, pitch, roll,
                    input ready);
    modport sink   (input valid, op, vec_x, vec_y, vec_z, yaw, pitch, roll,
                    output ready);
endinterface

interface ear_out_if #(
    parameter int VW = 18
);
    logic                 valid;
    logic                 ready;
    logic signed [VW-1:0] out_x;
    logic signed [VW-1:0] out_y;
    logic signed [VW-1:0] out_z;
    logic                 clipped;

    modport source (output valid, out_x, out_y, out_z, clipped, input ready);
    modport sink   (input valid, out_x, out_y, out_z, clipped, output ready);
endinterface

// ===== src/euler_attitude_rotation_top.sv =====
// ----------------------------------------------------------------------------
// euler_attitude_rotation_top
// Throughput: one item per cycle unless the output stalls; three chained
// pipelined CORDIC rotors set it.
// The whole pipeline advances when the output register is free or taken.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module euler_attitude_rotation_top
    import ear_pkg::*;
#(
    parameter int VEC_FRAC_BITS = VEC_FRAC_BITS_DEF,
    parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    ear_in_if.sink    in_ch,
    ear_out_if.source out_ch
);

    localparam int VW  = VEC_FRAC_BITS + 2;
    // Internal width: guard bits plus growth headroom through three rotations.
    localparam int IW  = VW + GUARD + 4;
    // Side payload: op, one leftover vector component, two pending angles.
    localparam int SW  = 1 + IW + 64;

    typedef struct packed {
        logic          op;
        logic [IW-1:0] c;
        logic [31:0]   ang1;
        logic [31:0]   ang2;
    } side_t;

    logic adv;
    logic rv1, rv2, rv3;
    logic ov_reg;

    // Advance whenever the output slot is empty or being drained.
    assign adv          = !ov_reg || out_ch.ready;
    assign in_ch.ready  = adv;

    // Entry: scale and turn angles into 32-bit turn units.
    logic signed [IW-1:0] ex, ey, ez;
    logic [31:0] ayaw, apitch, aroll;
    assign ex = IW'(in_ch.vec_x) <<< GUARD;
    assign ey = IW'(in_ch.vec_y) <<< GUARD;
    assign ez = IW'(in_ch.vec_z) <<< GUARD;
    assign ayaw   = {in_ch.yaw,   (32-ANGLE_BITS)'(0)};
    assign apitch = {in_ch.pitch, (32-ANGLE_BITS)'(0)};
    assign aroll  = {in_ch.roll,  (32-ANGLE_BITS)'(0)};

    // Stage 1: forward rolls (y,z); reverse yaws (x,y) by -yaw.
    logic signed [IW-1:0] a1, b1, r1a, r1b;
    logic [31:0] ang1;
    side_t s1, s1o;
    always_comb
    begin
        if (in_ch.op == OP_FORWARD)
        begin
            a1 = ey; b1 = ez; ang1 = aroll;
            s1 = '{op: in_ch.op, c: ex, ang1: apitch, ang2: ayaw};
        end
        else
        begin
            a1 = ex; b1 = ey; ang1 = 32'd0 - ayaw;
            s1 = '{op: in_ch.op, c: ez, ang1: 32'd0 - apitch, ang2: 32'd0 - aroll};
        end
    end

    ear_rotor #(.W(IW), .STAGES(CORDIC_STAGES), .SW(SW)) u_rot1 (
        .clk, .rst_n, .adv, .in_valid(in_ch.valid && adv),
        .in_a(a1), .in_b(b1), .in_ang(ang1), .in_side(s1),
        .out_valid(rv1), .out_a(r1a), .out_b(r1b), .out_side(s1o)
    );

    // Stage 2: pitch on (z,x) in both directions.
    // Forward: r1a=y, r1b=z, c=x. Reverse: r1a=x, r1b=y, c=z.
    logic signed [IW-1:0] a2, b2, r2a, r2b;
    side_t s2, s2o;
    always_comb
    begin
        if (s1o.op == OP_FORWARD)
        begin
            a2 = r1b; b2 = s1o.c;
            s2 = '{op: s1o.op, c: r1a, ang1: s1o.ang2, ang2: 32'd0};
        end
        else
        begin
            a2 = s1o.c; b2 = r1a;
            s2 = '{op: s1o.op, c: r1b, ang1: s1o.ang2, ang2: 32'd0};
        end
    end

    ear_rotor #(.W(IW), .STAGES(CORDIC_STAGES), .SW(SW)) u_rot2 (
        .clk, .rst_n, .adv, .in_valid(rv1),
        .in_a(a2), .in_b(b2), .in_ang(s1o.ang1), .in_side(s2),
        .out_valid(rv2), .out_a(r2a), .out_b(r2b), .out_side(s2o)
    );

    // Stage 3: forward yaws (x,y); reverse rolls (y,z).
    // Forward: r2a=z, r2b=x, c=y. Reverse: r2a=z, r2b=x, c=y.
    logic signed [IW-1:0] a3, b3, r3a, r3b;
    side_t s3, s3o;
    always_comb
    begin
        s3 = '{op: s2o.op, c: r2a, ang1: 32'd0, ang2: 32'd0};
        if (s2o.op == OP_FORWARD)
        begin
            a3 = r2b; b3 = s2o.c;
        end
        else
        begin
            a3 = s2o.c; b3 = r2a;
            s3.c = r2b;
        end
    end

    ear_rotor #(.W(IW), .STAGES(CORDIC_STAGES), .SW(SW)) u_rot3 (
        .clk, .rst_n, .adv, .in_valid(rv2),
        .in_a(a3), .in_b(b3), .in_ang(s2o.ang1), .in_side(s3),
        .out_valid(rv3), .out_a(r3a), .out_b(r3b), .out_side(s3o)
    );

    // Round off guard bits and saturate each component.
    logic signed [IW-1:0] fx, fy, fz;
    always_comb
    begin
        if (s3o.op == OP_FORWARD)
        begin
            fx = r3a; fy = r3b; fz = s3o.c;
        end
        else
        begin
            fx = s3o.c; fy = r3a; fz = r3b;
        end
    end

    localparam logic signed [IW-1:0] HI = IW'((64'sd1 <<< (VW-1)) - 1);
    localparam logic signed [IW-1:0] LO = -IW'(64'sd1 <<< (VW-1));

    function automatic logic [VW:0] sat(input logic signed [IW-1:0] v);
        logic signed [IW-1:0] r;
        begin
            r = (v + IW'(1 <<< (GUARD-1))) >>> GUARD;
            if (r > HI)      return {1'b1, HI[VW-1:0]};
            else if (r < LO) return {1'b1, LO[VW-1:0]};
            else             return {1'b0, r[VW-1:0]};
        end
    endfunction

    logic [VW:0] qx, qy, qz;
    assign qx = sat(fx);
    assign qy = sat(fy);
    assign qz = sat(fz);

    logic signed [VW-1:0] ox_reg, oy_reg, oz_reg;
    logic                 oc_reg;

    // Output register: hold until taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (adv)
            ov_reg <= rv3;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ox_reg <= qx[VW-1:0];
            oy_reg <= qy[VW-1:0];
            oz_reg <= qz[VW-1:0];
            oc_reg <= qx[VW] | qy[VW] | qz[VW];
        end
    end

    assign out_ch.valid   = ov_reg;
    assign out_ch.out_x   = ox_reg;
    assign out_ch.out_y   = oy_reg;
    assign out_ch.out_z   = oz_reg;
    assign out_ch.clipped = oc_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !out_ch.ready) |=> (ov_reg && $stable(ox_reg) && $stable(oc_reg)))
        else $error("stalled result changed");
    a_stall_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !out_ch.ready) |-> !in_ch.ready)
        else $error("accepted during stall");
    a_pipe_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable({rv1, rv2, rv3}))
        else $error("pipeline moved while stalled");

endmodule

// ===== src/ear_rotor.sv =====
// ----------------------------------------------------------------------------
// ear_rotor
// Pipelined CORDIC rotation of one pair (a, b) by a 32-bit turn angle,
// with fixed gain correction. One item per cycle while adv is high.
// ----------------------------------------------------------------------------
module ear_rotor
    import ear_pkg::*;
#(
    parameter int W      = 24,
    parameter int STAGES = 16,
    parameter int SW     = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_valid,
    input  logic signed [W-1:0] in_a,
    input  logic signed [W-1:0] in_b,
    input  logic [31:0]         in_ang,
    input  logic [SW-1:0]       in_side,
    output logic                out_valid,
    output logic signed [W-1:0] out_a,
    output logic signed [W-1:0] out_b,
    output logic [SW-1:0]       out_side
);

    localparam int N  = (STAGES < ATAN_COUNT) ? STAGES : ATAN_COUNT;
    localparam int WI = W + 2;
    localparam int PW = WI + KGAIN_W;

    logic signed [WI-1:0] a_reg [N+1];
    logic signed [WI-1:0] b_reg [N+1];
    logic signed [31:0]   t_reg [N+1];
    logic [SW-1:0]        s_reg [N+3];
    logic [N+2:0]         v_reg;
    logic signed [PW-1:0] pa_reg, pb_reg;
    logic signed [W-1:0]  ra_reg, rb_reg;

    logic signed [31:0] t0;
    logic               flip;
    assign t0   = in_ang;
    assign flip = (t0 > $signed(QUARTER_TURN)) || (t0 < -$signed(QUARTER_TURN));

    // Prerotation stage: fold angles beyond a quarter turn.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg[0] <= flip ? -WI'(in_a) : WI'(in_a);
            b_reg[0] <= flip ? -WI'(in_b) : WI'(in_b);
            t_reg[0] <= flip ? (t0 ^ 32'sh8000_0000) : t0;
            s_reg[0] <= in_side;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_stage
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (!t_reg[i][31])
                begin
                    a_reg[i+1] <= a_reg[i] - (b_reg[i] >>> i);
                    b_reg[i+1] <= b_reg[i] + (a_reg[i] >>> i);
                    t_reg[i+1] <= t_reg[i] - $signed(atan_turn(i));
                end
                else
                begin
                    a_reg[i+1] <= a_reg[i] + (b_reg[i] >>> i);
                    b_reg[i+1] <= b_reg[i] - (a_reg[i] >>> i);
                    t_reg[i+1] <= t_reg[i] + $signed(atan_turn(i));
                end
                s_reg[i+1] <= s_reg[i];
            end
        end
    end

    // Gain multiply, then round and narrow.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pa_reg <= PW'(a_reg[N]) * $signed({1'b0, KGAIN});
            pb_reg <= PW'(b_reg[N]) * $signed({1'b0, KGAIN});
            s_reg[N+1] <= s_reg[N];
            ra_reg <= W'((pa_reg + (PW'(1) <<< (KSHIFT-1))) >>> KSHIFT);
            rb_reg <= W'((pb_reg + (PW'(1) <<< (KSHIFT-1))) >>> KSHIFT);
            s_reg[N+2] <= s_reg[N+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[N+1:0], in_valid};
    end

    assign out_valid = v_reg[N+2];
    assign out_a     = ra_reg;
    assign out_b     = rb_reg;
    assign out_side  = s_reg[N+2];

endmodule
